// File: hdl/iqdc_pkg.sv
`timescale 1ns / 1ps
package iqdc_pkg;

	localparam int SAMPLE_RATE     = 2048000;
	localparam int SINE_TABLE_BITS = 10;
	localparam int TAB_N           = 1 << SINE_TABLE_BITS;
	localparam int IDX_W           = SINE_TABLE_BITS + 2;
	localparam int PHASE_W         = 21;
	localparam int FRAC_BITS       = 24;
	localparam int MEAN_W          = 40;
	localparam int ACC_W           = 42;
	localparam int RECIP_SH        = 32;
	// Scaled reciprocal of the sample rate, rounded up, for the phase to index map.
	localparam longint unsigned RECIP_M =
		((64'd1 << (RECIP_SH + IDX_W)) + SAMPLE_RATE - 1) / SAMPLE_RATE;
	localparam int RECIP_W = $clog2(RECIP_M + 1);

	localparam logic [1:0] REG_DC_ENABLE   = 2'd0;
	localparam logic [1:0] REG_DC_SHIFT    = 2'd1;
	localparam logic [1:0] REG_LEVEL_SHIFT = 2'd2;

	typedef struct packed {
		logic       en;
		logic [4:0] dsh;
		logic [4:0] lsh;
	} cfg_t;

	typedef struct packed {
		logic signed [15:0]   vi;
		logic signed [15:0]   vq;
		logic [PHASE_W-1:0]   phase;
		logic                 clr;
	} item_t;

	typedef logic [14:0] rom_t [0:TAB_N];

	function automatic logic [4:0] clamp_shift(input logic [4:0] v);
		logic [4:0] r;
		r = v;
		if (v < 5'd1) r = 5'd1;
		if (v > 5'd24) r = 5'd24;
		return r;
	endfunction

	// Quarter-wave sine table built at elaboration by a truncating Q30 series.
	function automatic rom_t build_rom();
		rom_t rom;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		logic [63:0] r;
		for (int k = 0; k <= TAB_N; k++) begin
			x = (64'(k) * 64'd1686629713) >> SINE_TABLE_BITS;
			x2 = (x * x) >> 30;
			t = 64'd1 << 30;
			t = (64'd1 << 30) - (((x2 * t) >> 30) / 64'd110);
			t = (64'd1 << 30) - (((x2 * t) >> 30) / 64'd72);
			t = (64'd1 << 30) - (((x2 * t) >> 30) / 64'd42);
			t = (64'd1 << 30) - (((x2 * t) >> 30) / 64'd20);
			t = (64'd1 << 30) - (((x2 * t) >> 30) / 64'd6);
			s = (x * t) >> 30;
			r = (s * 64'd32767 + (64'd1 << 29)) >> 30;
			if (r > 64'd32767) r = 64'd32767;
			rom[k] = r[14:0];
		end
		return rom;
	endfunction

endpackage

// File: hdl/iq_dc_removal_level_meter_mixer.sv
`timescale 1ns / 1ps
// DC blocker, level meter and oscillator frequency shift for complex samples.
// Input channel (in_valid/in_ready) carries sample_i, sample_q, freq_offset_hz and
// clear_peak. Output channel (out_valid/out_ready) carries out_i, out_q, level_mean
// and peak_level, exactly one transfer for every input transfer, in order.
// The front part takes a transfer, updates the DC means and the phase counter and
// pushes the corrected sample into a two-entry queue.
// The back part computes the magnitude with a bit-serial square root that resolves
// one result bit per cycle; the table lookup and mixing run alongside it.
// The back part finishes one sample before it takes the next from the queue, so it
// sets the sustained rate; the front part can accept a sample while the queue has room.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once; the user must
// make them only while the block is idle; the block does not enforce it. Writing
// the enable register clears both means. Reset clears the means, level, peak, phase
// and queue and loads the register defaults (enable 0, DC shift 21, level shift 17).
// When the receiver stalls, the finished result holds in the output register, the
// back part waits, the queue fills, and then the front part stops accepting samples.
module iq_dc_removal_level_meter_mixer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [4:0]         cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] sample_i,
	input  logic signed [15:0] sample_q,
	input  logic signed [20:0] freq_offset_hz,
	input  logic               clear_peak,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] out_i,
	output logic signed [15:0] out_q,
	output logic [15:0]        level_mean,
	output logic [15:0]        peak_level
);
	import iqdc_pkg::*;

	cfg_t   cfg_q;
	logic   mean_clr;
	logic   push, full, pop, not_empty;
	item_t  push_item, pop_item;

	// Any write to the enable register restarts the DC means.
	assign mean_clr = cfg_we && (cfg_index == REG_DC_ENABLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.en <= 1'b0;
			cfg_q.dsh <= 5'd21;
			cfg_q.lsh <= 5'd17;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DC_ENABLE:   cfg_q.en <= cfg_data[0];
				REG_DC_SHIFT:    cfg_q.dsh <= cfg_data;
				REG_LEVEL_SHIFT: cfg_q.lsh <= cfg_data;
				default: ;
			endcase
		end
	end

	iqdc_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.sample_i(sample_i), .sample_q(sample_q),
		.freq_offset_hz(freq_offset_hz), .clear_peak(clear_peak),
		.cfg(cfg_q), .mean_clr(mean_clr),
		.full(full), .push(push), .push_item(push_item)
	);

	iqdc_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.push(push), .push_item(push_item), .full(full),
		.pop(pop), .not_empty(not_empty), .pop_item(pop_item)
	);

	iqdc_back u_back (
		.clk(clk), .arst_n(arst_n),
		.not_empty(not_empty), .pop_item(pop_item), .pop(pop),
		.cfg(cfg_q),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_i(out_i), .out_q(out_q),
		.level_mean(level_mean), .peak_level(peak_level)
	);

endmodule

// File: hdl/iqdc_front.sv
`timescale 1ns / 1ps
module iqdc_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic signed [15:0]     sample_i,
	input  logic signed [15:0]     sample_q,
	input  logic signed [20:0]     freq_offset_hz,
	input  logic                   clear_peak,
	input  iqdc_pkg::cfg_t         cfg,
	input  logic                   mean_clr,
	input  logic                   full,
	output logic                   push,
	output iqdc_pkg::item_t        push_item
);
	import iqdc_pkg::*;

	typedef enum logic [1:0] {F_IDLE, F_MEAN, F_CORR} fstate_t;

	fstate_t                   state_q;
	logic signed [15:0]        xi_q, xq_q;
	logic signed [20:0]        off_q;
	logic                      clr_q;
	logic signed [MEAN_W-1:0]  mean_i_q, mean_q_q;
	logic [PHASE_W-1:0]        phase_q;

	logic [4:0]                dsh;
	logic signed [MEAN_W:0]    di, dq;
	logic signed [22:0]        pd;
	logic signed [16:0]        ci, cq;
	logic signed [15:0]        vi, vq;

	always_comb begin
		dsh = clamp_shift(cfg.dsh);
		di = $signed({xi_q[15], xi_q, 24'd0}) - $signed({mean_i_q[MEAN_W-1], mean_i_q});
		dq = $signed({xq_q[15], xq_q, 24'd0}) - $signed({mean_q_q[MEAN_W-1], mean_q_q});
		di = di >>> dsh;
		dq = dq >>> dsh;
		pd = $signed({2'b00, phase_q}) - $signed({{2{off_q[20]}}, off_q});
		if (pd < 0) begin
			pd = pd + 23'(SAMPLE_RATE);
		end else if (pd >= 23'(SAMPLE_RATE)) begin
			pd = pd - 23'(SAMPLE_RATE);
		end
		ci = $signed({xi_q[15], xi_q}) - $signed({mean_i_q[MEAN_W-1], mean_i_q[MEAN_W-1 -: 16]});
		cq = $signed({xq_q[15], xq_q}) - $signed({mean_q_q[MEAN_W-1], mean_q_q[MEAN_W-1 -: 16]});
		vi = (ci > 17'sd32767) ? 16'sh7fff : (ci < -17'sd32768) ? 16'sh8000 : ci[15:0];
		vq = (cq > 17'sd32767) ? 16'sh7fff : (cq < -17'sd32768) ? 16'sh8000 : cq[15:0];
		if (!cfg.en) begin
			vi = xi_q;
			vq = xq_q;
		end
		push_item.vi = vi;
		push_item.vq = vq;
		push_item.phase = phase_q;
		push_item.clr = clr_q;
	end

	assign in_ready = (state_q == F_IDLE);
	assign push = (state_q == F_CORR) && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			mean_i_q <= '0;
			mean_q_q <= '0;
			phase_q <= '0;
		end else begin
			if (mean_clr) begin
				mean_i_q <= '0;
				mean_q_q <= '0;
			end
			case (state_q)
				F_IDLE: begin
					if (in_valid) begin
						xi_q <= sample_i;
						xq_q <= sample_q;
						off_q <= freq_offset_hz;
						clr_q <= clear_peak;
						state_q <= F_MEAN;
					end
				end
				F_MEAN: begin
					if (cfg.en && !mean_clr) begin
						mean_i_q <= mean_i_q + di[MEAN_W-1:0];
						mean_q_q <= mean_q_q + dq[MEAN_W-1:0];
					end
					phase_q <= pd[PHASE_W-1:0];
					state_q <= F_CORR;
				end
				F_CORR: begin
					if (!full) state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

endmodule

// File: hdl/iqdc_fifo.sv
`timescale 1ns / 1ps
module iqdc_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  iqdc_pkg::item_t  push_item,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output iqdc_pkg::item_t  pop_item
);
	import iqdc_pkg::*;

	item_t       mem_q [0:1];
	logic        wr_q, rd_q;
	logic [1:0]  count_q;

	assign full = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign pop_item = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

endmodule

// File: hdl/iqdc_back.sv
`timescale 1ns / 1ps
module iqdc_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               not_empty,
	input  iqdc_pkg::item_t    pop_item,
	output logic               pop,
	input  iqdc_pkg::cfg_t     cfg,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] out_i,
	output logic signed [15:0] out_q,
	output logic [15:0]        level_mean,
	output logic [15:0]        peak_level
);
	import iqdc_pkg::*;

	typedef enum logic [1:0] {B_IDLE, B_PREP, B_ITER, B_FIN} bstate_t;

	localparam rom_t SINE_ROM = build_rom();

	bstate_t                     state_q;
	logic [3:0]                  cnt_q;
	logic signed [15:0]          vi_q, vq_q;
	logic [PHASE_W-1:0]          ph_q;
	logic                        clr_q;
	logic [30:0]                 sqi_q, sqq_q;
	logic [PHASE_W+RECIP_W-1:0]  prod_q;
	logic [IDX_W:0]              qest_q;
	logic [IDX_W-1:0]            idx_q;
	logic [31:0]                 rad_q;
	logic [18:0]                 rem_q;
	logic [15:0]                 root_q;
	logic [14:0]                 si_q, ci_q;
	logic [1:0]                  quad_q;
	logic signed [31:0]          pic_q, pqs_q, pis_q, pqc_q;
	logic signed [15:0]          res_i_q, res_q_q;
	logic [ACC_W-1:0]            acc_q;
	logic [15:0]                 peak_q;

	logic [18:0]                 rem_sh, trial;
	logic [PHASE_W+IDX_W+1:0]    qr, pscaled;
	logic signed [15:0]          s_v, c_v;
	logic signed [32:0]          sum_i, sum_q;
	logic signed [17:0]          sh_i, sh_q;
	logic signed [ACC_W:0]       ldiff;
	logic [ACC_W-1:0]            acc_new;
	logic [15:0]                 pk;
	logic                        fin_go;
	logic [SINE_TABLE_BITS:0]    caddr;

	always_comb begin
		rem_sh = {rem_q[16:0], rad_q[31:30]};
		trial = {1'b0, root_q, 2'b01};
		qr = (PHASE_W+IDX_W+2)'(qest_q * SAMPLE_RATE[PHASE_W-1:0]);
		pscaled = (PHASE_W+IDX_W+2)'({ph_q, {IDX_W{1'b0}}});
		caddr = (SINE_TABLE_BITS+1)'(TAB_N) - {1'b0, idx_q[SINE_TABLE_BITS-1:0]};
		case (quad_q)
			2'd0: begin s_v = $signed({1'b0, si_q}); c_v = $signed({1'b0, ci_q}); end
			2'd1: begin s_v = $signed({1'b0, ci_q}); c_v = -$signed({1'b0, si_q}); end
			2'd2: begin s_v = -$signed({1'b0, si_q}); c_v = -$signed({1'b0, ci_q}); end
			default: begin s_v = -$signed({1'b0, ci_q}); c_v = $signed({1'b0, si_q}); end
		endcase
		sum_i = 33'(pic_q) - 33'(pqs_q) + 33'sd16384;
		sum_q = 33'(pis_q) + 33'(pqc_q) + 33'sd16384;
		sh_i = 18'(sum_i >>> 15);
		sh_q = 18'(sum_q >>> 15);
		ldiff = $signed({3'b000, root_q, 24'd0}) - $signed({1'b0, acc_q});
		ldiff = ldiff >>> clamp_shift(cfg.lsh);
		acc_new = acc_q + ldiff[ACC_W-1:0];
		pk = (root_q > peak_q) ? root_q : peak_q;
		fin_go = (state_q == B_FIN) && (!out_valid || out_ready);
	end

	assign pop = (state_q == B_IDLE) && not_empty;

	always_ff @(posedge clk) begin
		si_q <= SINE_ROM[idx_q[SINE_TABLE_BITS-1:0]];
		ci_q <= SINE_ROM[caddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			out_valid <= 1'b0;
			acc_q <= '0;
			peak_q <= '0;
			cnt_q <= '0;
		end else begin
			if (out_valid && out_ready && !fin_go) out_valid <= 1'b0;
			case (state_q)
				B_IDLE: begin
					if (not_empty) begin
						vi_q <= pop_item.vi;
						vq_q <= pop_item.vq;
						ph_q <= pop_item.phase;
						clr_q <= pop_item.clr;
						sqi_q <= 31'(pop_item.vi * pop_item.vi);
						sqq_q <= 31'(pop_item.vq * pop_item.vq);
						prod_q <= pop_item.phase * RECIP_M[RECIP_W-1:0];
						state_q <= B_PREP;
					end
				end
				B_PREP: begin
					rad_q <= 32'(sqi_q) + 32'(sqq_q);
					rem_q <= '0;
					root_q <= '0;
					qest_q <= prod_q[RECIP_SH +: IDX_W+1];
					cnt_q <= '0;
					state_q <= B_ITER;
				end
				B_ITER: begin
					rad_q <= {rad_q[29:0], 2'b00};
					if (rem_sh >= trial) begin
						rem_q <= rem_sh - trial;
						root_q <= {root_q[14:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						root_q <= {root_q[14:0], 1'b0};
					end
					case (cnt_q)
						4'd0: idx_q <= (qr > pscaled) ? IDX_W'(qest_q - 1'b1) : qest_q[IDX_W-1:0];
						4'd1: quad_q <= idx_q[IDX_W-1 -: 2];
						4'd2: begin
							pic_q <= vi_q * c_v;
							pqs_q <= vq_q * s_v;
							pis_q <= vi_q * s_v;
							pqc_q <= vq_q * c_v;
						end
						4'd3: begin
							res_i_q <= (sh_i > 18'sd32767) ? 16'sh7fff :
								(sh_i < -18'sd32768) ? 16'sh8000 : sh_i[15:0];
							res_q_q <= (sh_q > 18'sd32767) ? 16'sh7fff :
								(sh_q < -18'sd32768) ? 16'sh8000 : sh_q[15:0];
						end
						default: ;
					endcase
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 4'd15) state_q <= B_FIN;
				end
				B_FIN: begin
					if (fin_go) begin
						acc_q <= acc_new;
						peak_q <= clr_q ? 16'd0 : pk;
						out_i <= res_i_q;
						out_q <= res_q_q;
						level_mean <= acc_new[FRAC_BITS +: 16];
						peak_level <= pk;
						out_valid <= 1'b1;
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	a_iter_end: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_ITER && cnt_q == 4'd15 |=> state_q == B_FIN)
		else $error("square root sequence did not end after sixteen steps");

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> state_q == B_IDLE && !out_valid || state_q == B_IDLE)
		else $error("queue read outside idle state");

	a_peak_ge: assert property (@(posedge clk) disable iff (!arst_n)
		fin_go |=> peak_level >= $past(root_q))
		else $error("reported peak below current magnitude");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import iqdc_pkg::*;

	// Result fields of one transfer on the output channel.
	typedef struct {
		logic signed [15:0] oi;
		logic signed [15:0] oq;
		logic [15:0]        lvl;
		logic [15:0]        pk;
	} mix_res_t;

	// One row of the directed table. When has_exp is set, the row carries a
	// result that can be read straight off the block's behavior.
	typedef struct {
		logic signed [15:0] si;
		logic signed [15:0] sq;
		logic signed [20:0] off;
		logic               clr;
		logic               has_exp;
		mix_res_t           res;
	} dir_row_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [1:0]         cfg_index;
	logic [4:0]         cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic signed [15:0] sample_i;
	logic signed [15:0] sample_q;
	logic signed [20:0] freq_offset_hz;
	logic               clear_peak;
	logic               out_valid;
	logic               out_ready;
	logic signed [15:0] out_i;
	logic signed [15:0] out_q;
	logic [15:0]        level_mean;
	logic [15:0]        peak_level;

	iq_dc_removal_level_meter_mixer u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.sample_i(sample_i), .sample_q(sample_q),
		.freq_offset_hz(freq_offset_hz), .clear_peak(clear_peak),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_i(out_i), .out_q(out_q),
		.level_mean(level_mean), .peak_level(peak_level)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Predictor state: our own copy of the registers and the datapath state.
	logic [4:0]          m_en;
	logic [4:0]          m_dsh;
	logic [4:0]          m_lsh;
	logic signed [63:0]  m_mean_i;
	logic signed [63:0]  m_mean_q;
	logic signed [63:0]  m_level;
	logic [15:0]         m_peak;
	logic signed [63:0]  m_phase;
	logic [15:0]         sin_tab [0:1024];

	mix_res_t expected_q [$];
	int errors;
	int n_sent;
	int n_checked;
	int idle_pct_in;
	int idle_pct_out;
	bit hold_off;
	// A directed row with a typed result queues that result instead of the prediction.
	bit use_typed;
	mix_res_t typed_res;

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("  mismatch at result %0d: %s got %0d want %0d", n_checked, what, got, want);
		errors++;
	endtask

	// The quarter-wave table is computed here with the same truncating series.
	task automatic build_sine_table();
		longint unsigned x, x2, t, s, r;
		longint unsigned dv [5];
		dv = '{110, 72, 42, 20, 6};
		for (int k = 0; k <= 1024; k++) begin
			x = (longint'(k) * 64'd1686629713) >> 10;
			x2 = (x * x) >> 30;
			t = 64'd1 << 30;
			for (int j = 0; j < 5; j++)
				t = (64'd1 << 30) - (((x2 * t) >> 30) / dv[j]);
			s = (x * t) >> 30;
			r = (s * 64'd32767 + (64'd1 << 29)) >> 30;
			if (r > 32767) r = 32767;
			sin_tab[k] = r[15:0];
		end
	endtask

	function automatic int clip_shift(input logic [4:0] v);
		if (v < 1) return 1;
		if (v > 24) return 24;
		return v;
	endfunction

	function automatic longint clip16(input longint v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	function automatic longint unsigned root_floor(input longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	// Computes the output of one sample and advances the predictor state.
	function automatic mix_res_t mix_predict(input logic signed [15:0] xi,
			input logic signed [15:0] xq, input logic signed [20:0] off, input logic clr);
		mix_res_t rr;
		longint vi, vq, c, s, si, ci, p, idx;
		longint unsigned mag;
		int quad, r, dsh, lsh;
		vi = xi;
		vq = xq;
		lsh = clip_shift(m_lsh);
		if (m_en[0]) begin
			dsh = clip_shift(m_dsh);
			m_mean_i += ((longint'(xi) <<< 24) - m_mean_i) >>> dsh;
			m_mean_q += ((longint'(xq) <<< 24) - m_mean_q) >>> dsh;
			vi = clip16(longint'(xi) - (m_mean_i >>> 24));
			vq = clip16(longint'(xq) - (m_mean_q >>> 24));
		end
		mag = root_floor(vi * vi + vq * vq);
		if (mag > m_peak) m_peak = mag[15:0];
		m_level += ((longint'(mag) <<< 24) - m_level) >>> lsh;
		p = (m_phase - longint'(off)) % 2048000;
		if (p < 0) p += 2048000;
		m_phase = p;
		idx = (p * 4096) / 2048000;
		quad = int'((idx >> 10) & 3);
		r = int'(idx & 1023);
		si = sin_tab[r];
		ci = sin_tab[1024 - r];
		case (quad)
			0: begin s = si; c = ci; end
			1: begin s = ci; c = -si; end
			2: begin s = -si; c = -ci; end
			default: begin s = -ci; c = si; end
		endcase
		rr.oi = 16'(clip16((vi * c - vq * s + 16384) >>> 15));
		rr.oq = 16'(clip16((vi * s + vq * c + 16384) >>> 15));
		rr.lvl = 16'(m_level >>> 24);
		rr.pk = m_peak;
		if (clr) m_peak = 0;
		return rr;
	endfunction

	// Writes one register in the block and in the predictor.
	task automatic write_reg(input logic [1:0] idx, input logic [4:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_DC_ENABLE) begin
			m_en = {4'd0, val[0]};
			m_mean_i = 0;
			m_mean_q = 0;
		end else if (idx == REG_DC_SHIFT) begin
			m_dsh = val;
		end else if (idx == REG_LEVEL_SHIFT) begin
			m_lsh = val;
		end
		@(negedge clk);
	endtask

	// Offers one transfer on the input channel; valid stays up until accepted.
	task automatic send_sample(input logic signed [15:0] xi, input logic signed [15:0] xq,
			input logic signed [20:0] off, input logic clr);
		mix_res_t want;
		while (idle_pct_in > 0 && $urandom_range(99, 0) < idle_pct_in) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		sample_i <= xi;
		sample_q <= xq;
		freq_offset_hz <= off;
		clear_peak <= clr;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		want = mix_predict(xi, xq, off, clr);
		if (use_typed) want = typed_res;
		expected_q.push_back(want);
		n_sent++;
		@(negedge clk);
	endtask

	// Waits until every expected result has come back, plus settling time.
	task automatic drain();
		int guard;
		in_valid <= 1'b0;
		guard = 0;
		while (expected_q.size() != 0 && guard < 200000) begin
			@(negedge clk);
			guard++;
		end
		repeat (40) @(negedge clk);
	endtask

	function automatic logic signed [20:0] rand_offset();
		int k;
		k = $urandom_range(9, 0);
		if (k == 0) return 21'sd1024000;
		if (k == 1) return -21'sd1024000;
		if (k < 5) return 21'($signed($urandom_range(4000, 0)) - 2000);
		return 21'($signed($urandom_range(2048000, 0)) - 1024000);
	endfunction

	function automatic logic signed [15:0] rand_sample();
		if ($urandom_range(7, 0) == 0)
			return $urandom_range(1, 0) ? 16'sh7fff : 16'sh8000;
		return 16'($urandom());
	endfunction

	// Receiver: stalls at random by the current percentage, or holds off entirely.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= !hold_off && !(idle_pct_out > 0 && $urandom_range(99, 0) < idle_pct_out);
		end
	end

	// Checker: every output transfer is compared with the oldest expectation.
	always @(posedge clk) begin
		mix_res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				report_mismatch("unexpected transfer, out_i", out_i, 0);
			end else begin
				want = expected_q.pop_front();
				if (out_i !== want.oi) report_mismatch("out_i", out_i, want.oi);
				if (out_q !== want.oq) report_mismatch("out_q", out_q, want.oq);
				if (level_mean !== want.lvl) report_mismatch("level_mean", level_mean, want.lvl);
				if (peak_level !== want.pk) report_mismatch("peak_level", peak_level, want.pk);
			end
			n_checked++;
		end
	end

	// Long stretch with the receiver held off, counted in cycles, so the queue
	// inside the block fills and in_ready drops while samples keep coming.
	initial begin
		hold_off = 1'b0;
		wait (n_sent == 60);
		@(negedge clk);
		hold_off = 1'b1;
		repeat (300) @(negedge clk);
		hold_off = 1'b0;
	end

	initial begin
		#40_000_000;
		$display("timeout with %0d results outstanding", expected_q.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		dir_row_t rows [$];
		dir_row_t row;
		mix_res_t zero_res;
		int phase_cfg;
		errors = 0;
		n_sent = 0;
		n_checked = 0;
		idle_pct_in = 0;
		idle_pct_out = 0;
		use_typed = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_DC_ENABLE;
		cfg_data = 5'd0;
		in_valid = 1'b0;
		sample_i = 16'sd0;
		sample_q = 16'sd0;
		freq_offset_hz = 21'sd0;
		clear_peak = 1'b0;
		build_sine_table();
		m_en = 0;
		m_dsh = 21;
		m_lsh = 17;
		m_mean_i = 0;
		m_mean_q = 0;
		m_level = 0;
		m_peak = 0;
		m_phase = 0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed table. A zero sample at phase zero gives an all-zero result right
		// after reset; the remaining rows go through the predictor.
		zero_res = '{oi: 16'sd0, oq: 16'sd0, lvl: 16'd0, pk: 16'd0};
		rows.push_back('{16'sd0, 16'sd0, 21'sd0, 1'b0, 1'b1, zero_res});
		// Full-scale corners, extreme offsets, quadrant walk and peak clears.
		rows.push_back('{16'sh7fff, 16'sh7fff, 21'sd0, 1'b0, 1'b0, zero_res});
		rows.push_back('{16'sh8000, 16'sh8000, 21'sd0, 1'b1, 1'b0, zero_res});
		rows.push_back('{16'sh8000, 16'sh7fff, 21'sd1024000, 1'b0, 1'b0, zero_res});
		rows.push_back('{16'sh7fff, 16'sh8000, -21'sd1024000, 1'b0, 1'b0, zero_res});
		rows.push_back('{16'sd1000, 16'sd0, -21'sd512000, 1'b0, 1'b0, zero_res});
		rows.push_back('{16'sd1000, 16'sd0, -21'sd512000, 1'b0, 1'b0, zero_res});
		rows.push_back('{16'sd1000, 16'sd0, -21'sd512000, 1'b0, 1'b0, zero_res});
		rows.push_back('{16'sd1000, 16'sd0, -21'sd512000, 1'b1, 1'b0, zero_res});
		rows.push_back('{16'sd0, 16'sd0, 21'sd1, 1'b0, 1'b0, zero_res});
		rows.push_back('{-16'sd1, 16'sd1, -21'sd1, 1'b0, 1'b0, zero_res});
		rows.push_back('{16'sh5555, 16'shaaaa, 21'sh0aaaaa, 1'b0, 1'b0, zero_res});
		rows.push_back('{16'shaaaa, 16'sh5555, 21'sh155555, 1'b1, 1'b0, zero_res});
		foreach (rows[k]) begin
			row = rows[k];
			use_typed = row.has_exp;
			typed_res = row.res;
			send_sample(row.si, row.sq, row.off, row.clr);
		end
		use_typed = 1'b0;
		drain();

		// DC removal at its smallest shift, and out-of-range shift values.
		write_reg(REG_DC_ENABLE, 5'd1);
		write_reg(REG_DC_SHIFT, 5'd1);
		write_reg(REG_LEVEL_SHIFT, 5'd1);
		for (int k = 0; k < 6; k++)
			send_sample(16'sh7fff, 16'sh8000, 21'sd0, 1'b0);
		drain();
		write_reg(REG_DC_SHIFT, 5'd0);
		write_reg(REG_LEVEL_SHIFT, 5'd31);
		for (int k = 0; k < 4; k++)
			send_sample(16'sh8000, 16'sh7fff, 21'sd1000, 1'b0);
		drain();
		// An unknown register index must be ignored.
		write_reg(2'd3, 5'd7);

		// Random part in phases of configuration and idling.
		for (phase_cfg = 0; phase_cfg < 8; phase_cfg++) begin
			case (phase_cfg % 4)
				0: begin idle_pct_in = 0; idle_pct_out = 0; end
				1: begin idle_pct_in = 55; idle_pct_out = 0; end
				2: begin idle_pct_in = 0; idle_pct_out = 55; end
				default: begin idle_pct_in = 9; idle_pct_out = 9; end
			endcase
			write_reg(REG_DC_ENABLE, 5'($urandom_range(1, 0)));
			write_reg(REG_DC_SHIFT, phase_cfg == 3 ? 5'd24 : 5'($urandom_range(31, 0)));
			write_reg(REG_LEVEL_SHIFT, phase_cfg == 5 ? 5'd24 : 5'($urandom_range(31, 0)));
			for (int k = 0; k < 54; k++)
				send_sample(rand_sample(), rand_sample(), rand_offset(),
					$urandom_range(15, 0) == 0);
			drain();
		end

		$display("covered %0d samples, %0d results checked, across DC on/off,", n_sent, n_checked);
		$display("shift extremes, offset extremes, peak clears and back-pressure");
		if (errors == 0 && expected_q.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("%0d mismatches, %0d results never came", errors, expected_q.size());
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// File: filelist.f
hdl/iqdc_pkg.sv
hdl/iqdc_front.sv
hdl/iqdc_fifo.sv
hdl/iqdc_back.sv
hdl/iq_dc_removal_level_meter_mixer.sv
tb/tb_top.sv
